// ===== hw/rtl/s88rd_pkg.sv =====
package s88rd_pkg;

   localparam int MaxModulesDefault = 32;

   localparam int KindW    = 2;
   localparam int CountW   = 6;
   localparam int EdgeW    = 10;
   localparam int IndexW   = 6;
   localparam int ByteIdxW = 5;
   localparam int ByteW    = 8;
   localparam int LineW    = 3;

   localparam int BitsPerModule   = 8;
   localparam int EdgesPerBit     = 2;
   localparam int EdgesPerModule  = EdgesPerBit * BitsPerModule;
   localparam int EdgeProdW       = CountW + 1 + $clog2(EdgesPerModule);

   localparam logic [ByteW-1:0] MaskTop = ByteW'(128);

   localparam int LineClk  = 0;
   localparam int LineLoad = 1;
   localparam int LineRst  = 2;

   localparam logic [CountW-1:0] CountReset = CountW'(1);

   typedef enum logic [8:0] {
      PH_IDLE      = 9'b0_0000_0001,
      PH_START     = 9'b0_0000_0010,
      PH_CLK_UP    = 9'b0_0000_0100,
      PH_CLK_DOWN  = 9'b0_0000_1000,
      PH_RST_HIGH  = 9'b0_0001_0000,
      PH_RST_LOW   = 9'b0_0010_0000,
      PH_LOAD_DROP = 9'b0_0100_0000,
      PH_CLOCK     = 9'b0_1000_0000,
      PH_READY     = 9'b1_0000_0000
   } phase_type;

   typedef enum logic [KindW-1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_RESET = 2'd2
   } kind_type;

   typedef struct packed {
      phase_type         phase;
      logic [EdgeW-1:0]  edges_left;
      logic [IndexW-1:0] module_index;
      logic [ByteW-1:0]  bit_mask;
      logic [ByteW-1:0]  byte_acc;
      logic [LineW-1:0]  line_levels;
   } seq_state_type;

   localparam seq_state_type StateReset = '{
      phase:        PH_IDLE,
      edges_left:   '0,
      module_index: '0,
      bit_mask:     MaskTop,
      byte_acc:     '0,
      line_levels:  '0
   };

   typedef struct packed {
      logic                clock_level;
      logic                load_level;
      logic                reset_level;
      logic                ready_res;
      logic                byte_valid;
      logic [ByteIdxW-1:0] byte_index;
      logic [ByteW-1:0]    byte_value;
   } result_type;

endpackage

// ===== hw/rtl/s88rd_if.sv =====
interface s88rd_req_if;
   import s88rd_pkg::*;
   logic             valid;
   logic             ready;
   logic [KindW-1:0] kind;
   logic             data_line;

   modport source (output valid, kind, data_line, input ready);
   modport sink (input valid, kind, data_line, output ready);
endinterface

interface s88rd_rsp_if;
   import s88rd_pkg::*;
   logic                valid;
   logic                ready;
   logic                clock_level;
   logic                load_level;
   logic                reset_level;
   logic                ready_res;
   logic                byte_valid;
   logic [ByteIdxW-1:0] byte_index;
   logic [ByteW-1:0]    byte_value;

   modport source (output valid, clock_level, load_level, reset_level, ready_res,
                   byte_valid, byte_index, byte_value, input ready);
   modport sink (input valid, clock_level, load_level, reset_level, ready_res,
                 byte_valid, byte_index, byte_value, output ready);
endinterface

interface s88rd_csr_if;
   import s88rd_pkg::*;
   logic              valid;
   logic              ready;
   logic [CountW-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/s88rd_step.sv =====
module s88rd_step
   import s88rd_pkg::*;
#(
   parameter int MAX_MODULES = MaxModulesDefault
) (
   input  seq_state_type     cur_state,
   input  logic [KindW-1:0]  req_kind,
   input  logic              req_data_line,
   input  logic [CountW-1:0] module_count,
   output seq_state_type     nxt_state,
   output result_type        result
);

   localparam logic [CountW:0] MaxCount = (CountW + 1)'(MAX_MODULES);

   logic [CountW:0]    count_sat;
   logic [EdgeProdW-1:0] edge_prod;
   logic [EdgeW-1:0]   edge_total;
   logic [EdgeW-1:0]   edges_dec;
   logic [ByteW-1:0]   mask_sh;

   always_comb begin
      count_sat = ({1'b0, module_count} > MaxCount) ? MaxCount : {1'b0, module_count};
      edge_prod = EdgeProdW'(count_sat) * EdgeProdW'(EdgesPerModule);
      edge_total = edge_prod[EdgeW-1:0];
      edges_dec = cur_state.edges_left - EdgeW'(1);
   end

   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      mask_sh   = '0;
      case (kind_type'(req_kind))
         KIND_START: begin
            nxt_state.phase        = PH_START;
            nxt_state.edges_left   = edge_total;
            nxt_state.module_index = '0;
            nxt_state.bit_mask     = MaskTop;
         end
         KIND_RESET: begin
            nxt_state.phase = PH_IDLE;
         end
         KIND_TICK: begin
            case (cur_state.phase)
               PH_START: begin
                  nxt_state.line_levels           = '0;
                  nxt_state.line_levels[LineLoad] = 1'b1;
                  nxt_state.phase                 = PH_CLK_UP;
               end
               PH_CLK_UP: begin
                  nxt_state.edges_left           = edges_dec;
                  nxt_state.line_levels[LineClk] = ~cur_state.line_levels[LineClk];
                  nxt_state.phase                = PH_CLK_DOWN;
               end
               PH_CLK_DOWN: begin
                  nxt_state.edges_left           = edges_dec;
                  nxt_state.bit_mask             = MaskTop;
                  nxt_state.line_levels[LineClk] = ~cur_state.line_levels[LineClk];
                  nxt_state.phase                = PH_RST_HIGH;
               end
               PH_RST_HIGH: begin
                  nxt_state.line_levels[LineRst] = ~cur_state.line_levels[LineRst];
                  nxt_state.phase                = PH_RST_LOW;
               end
               PH_RST_LOW: begin
                  nxt_state.line_levels[LineRst] = ~cur_state.line_levels[LineRst];
                  nxt_state.module_index         = '0;
                  nxt_state.phase                = PH_LOAD_DROP;
               end
               PH_LOAD_DROP: begin
                  nxt_state.line_levels[LineLoad] = ~cur_state.line_levels[LineLoad];
                  nxt_state.phase                 = PH_CLOCK;
               end
               PH_CLOCK: begin
                  nxt_state.line_levels[LineClk] = ~cur_state.line_levels[LineClk];
                  nxt_state.edges_left           = edges_dec;
                  if (cur_state.line_levels[LineClk]) begin
                     mask_sh = cur_state.bit_mask >> 1;
                     if (mask_sh == '0) begin
                        result.byte_valid      = 1'b1;
                        result.byte_index      = cur_state.module_index[ByteIdxW-1:0];
                        result.byte_value      = cur_state.byte_acc;
                        nxt_state.byte_acc     = '0;
                        nxt_state.module_index = cur_state.module_index + IndexW'(1);
                        mask_sh                = MaskTop;
                     end
                     nxt_state.bit_mask = mask_sh;
                     if (req_data_line) begin
                        nxt_state.byte_acc = nxt_state.byte_acc | mask_sh;
                     end
                  end
                  if (edges_dec == '0) begin
                     nxt_state.phase        = PH_READY;
                     nxt_state.module_index = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      result.clock_level = nxt_state.line_levels[LineClk];
      result.load_level  = nxt_state.line_levels[LineLoad];
      result.reset_level = nxt_state.line_levels[LineRst];
      result.ready_res   = (nxt_state.phase == PH_READY);
   end

endmodule

// ===== hw/rtl/s88rd_out_stage.sv =====
module s88rd_out_stage
   import s88rd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  result_type        result,
   output logic              room,
   s88rd_rsp_if.source       rsp_bus
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign room     = !valid_ff || rsp_bus.ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.clock_level = data_ff.clock_level;
   assign rsp_bus.load_level  = data_ff.load_level;
   assign rsp_bus.reset_level = data_ff.reset_level;
   assign rsp_bus.ready_res   = data_ff.ready_res;
   assign rsp_bus.byte_valid  = data_ff.byte_valid;
   assign rsp_bus.byte_index  = data_ff.byte_index;
   assign rsp_bus.byte_value  = data_ff.byte_value;

endmodule

// ===== hw/rtl/s88_bus_read_sequencer_core.sv =====
// Bus master sequencer for a shift-register feedback bus.
// req_bus carries one transaction per event: kind 0 is a timer tick, kind 1
// arms a read, kind 2 returns to idle; data_line is the sampled bus data input.
// Every accepted request transaction produces exactly one rsp_bus transaction:
// the clock, load and reset line levels after the event, the ready flag once
// the read is done, and a completed module byte with its index when one ends.
// csr_bus writes module_count (modules per bus, saturated at MAX_MODULES);
// write it only while no request is pending. csr_bus.ready is always high.
// rsp_bus.valid rises in the cycle after a request is accepted. One request
// is taken every cycle while rsp_bus.ready is high: the next-state logic is
// a single combinational pass between the sequencer state register and the
// result register. While a pending result waits on rsp_bus.ready it holds and
// req_bus.ready drops until the result is taken; nothing is lost or duplicated.
// Reset clears the sequencer to idle, drives all bus lines low, empties the
// result register and sets module_count to 1.
module s88_bus_read_sequencer_core
   import s88rd_pkg::*;
#(
   parameter int MAX_MODULES = MaxModulesDefault
) (
   input  logic        clock,
   input  logic        reset,
   s88rd_req_if.sink   req_bus,
   s88rd_rsp_if.source rsp_bus,
   s88rd_csr_if.sink   csr_bus
);

   seq_state_type     state_ff;
   seq_state_type     state_in;
   logic [CountW-1:0] count_ff;
   result_type        result;
   logic              room;
   logic              accept;

   assign req_bus.ready = room;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && room;

   s88rd_step #(
      .MAX_MODULES(MAX_MODULES)
   ) u_step (
      .cur_state    (state_ff),
      .req_kind     (req_bus.kind),
      .req_data_line(req_bus.data_line),
      .module_count (count_ff),
      .nxt_state    (state_in),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountReset;
      end else if (csr_bus.valid) begin
         count_ff <= csr_bus.data;
      end
   end

   s88rd_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .result (result),
      .room   (room),
      .rsp_bus(rsp_bus)
   );

endmodule

// ===== hw/rtl/s88rd_checker.sv =====
module s88rd_checker
   import s88rd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_clock_level,
   input logic                rsp_load_level,
   input logic                rsp_reset_level,
   input logic                rsp_ready_res,
   input logic                rsp_byte_valid,
   input logic [ByteIdxW-1:0] rsp_byte_index,
   input logic [ByteW-1:0]    rsp_byte_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_value)
         && $stable(rsp_byte_index) && $stable(rsp_byte_valid))
      else $error("result changed while stalled");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_byte_index == '0 && rsp_byte_value == '0)
      else $error("byte fields nonzero without a byte");

   a_byte_on_fall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_clock_level && !rsp_load_level
         && !rsp_reset_level && !rsp_ready_res)
      else $error("byte emitted outside a falling clock edge");

   a_ready_lines_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready_res |-> !rsp_clock_level && !rsp_load_level
         && !rsp_reset_level)
      else $error("bus lines not parked when read finished");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind s88_bus_read_sequencer_core s88rd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_clock_level(rsp_bus.clock_level),
   .rsp_load_level (rsp_bus.load_level),
   .rsp_reset_level(rsp_bus.reset_level),
   .rsp_ready_res  (rsp_bus.ready_res),
   .rsp_byte_valid (rsp_bus.byte_valid),
   .rsp_byte_index (rsp_bus.byte_index),
   .rsp_byte_value (rsp_bus.byte_value)
);
